// File: hw/rtl/assert_macros.svh
// assertion macros used by the top-level rtl file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define RAR_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// next-cycle implication, disabled in reset
`define RAR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// File: hw/rtl/rar_pkg.sv
// types, control word layout and microcode rom for the fraction adder
// no dependencies
package rar_pkg;

   localparam int STEP_W = 4;

   typedef logic [STEP_W-1:0] step_type;

   typedef enum logic [1:0] {
      MUL_NONE  = 2'd0,
      MUL_AN_BD = 2'd1,
      MUL_AD_BN = 2'd2,
      MUL_AD_BD = 2'd3
   } mul_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD = 2'd0,
      ACC_LOAD = 2'd1,
      ACC_ADD  = 2'd2
   } acc_op_type;

   typedef enum logic [2:0] {
      COND_NONE     = 3'd0,
      COND_ALWAYS   = 3'd1,
      COND_NO_REQ   = 3'd2,
      COND_ACC_ZERO = 3'd3,
      COND_GCD_BUSY = 3'd4,
      COND_DIV_BUSY = 3'd5,
      COND_OUT_BUSY = 3'd6
   } cond_type;

   typedef struct packed {
      logic        take;
      mul_sel_type mul_sel;
      acc_op_type  acc_op;
      logic        load_gcd;
      logic        gcd_step;
      logic        div_init;
      logic        div_step;
      logic        emit;
      logic        emit_zero;
      cond_type    cond;
      step_type    target;
   } ctrl_type;

   typedef struct packed {
      logic acc_zero;
      logic gcd_busy;
      logic div_busy;
   } dp_flags_type;

   typedef struct packed {
      logic         req_valid;
      logic         out_free;
      dp_flags_type flags;
   } status_type;

   localparam step_type STEP_IDLE  = STEP_W'(0);
   localparam step_type STEP_MUL1  = STEP_W'(1);
   localparam step_type STEP_MUL2  = STEP_W'(2);
   localparam step_type STEP_MUL3  = STEP_W'(3);
   localparam step_type STEP_LOAD  = STEP_W'(4);
   localparam step_type STEP_GCD   = STEP_W'(5);
   localparam step_type STEP_DINIT = STEP_W'(6);
   localparam step_type STEP_DIV   = STEP_W'(7);
   localparam step_type STEP_EMIT  = STEP_W'(8);
   localparam step_type STEP_RET   = STEP_W'(9);
   localparam step_type STEP_ZERO  = STEP_W'(10);
   localparam step_type STEP_RET2  = STEP_W'(11);

   function automatic ctrl_type ucode_rom(input step_type step);
      ctrl_type w;
      w.take      = 1'b0;
      w.mul_sel   = MUL_NONE;
      w.acc_op    = ACC_HOLD;
      w.load_gcd  = 1'b0;
      w.gcd_step  = 1'b0;
      w.div_init  = 1'b0;
      w.div_step  = 1'b0;
      w.emit      = 1'b0;
      w.emit_zero = 1'b0;
      w.cond      = COND_NONE;
      w.target    = STEP_IDLE;
      case (step)
         STEP_IDLE: begin
            w.take   = 1'b1;
            w.cond   = COND_NO_REQ;
            w.target = STEP_IDLE;
         end
         STEP_MUL1: begin
            w.mul_sel = MUL_AN_BD;
         end
         STEP_MUL2: begin
            w.mul_sel = MUL_AD_BN;
            w.acc_op  = ACC_LOAD;
         end
         STEP_MUL3: begin
            w.mul_sel = MUL_AD_BD;
            w.acc_op  = ACC_ADD;
         end
         STEP_LOAD: begin
            w.load_gcd = 1'b1;
            w.cond     = COND_ACC_ZERO;
            w.target   = STEP_ZERO;
         end
         STEP_GCD: begin
            w.gcd_step = 1'b1;
            w.cond     = COND_GCD_BUSY;
            w.target   = STEP_GCD;
         end
         STEP_DINIT: begin
            w.div_init = 1'b1;
         end
         STEP_DIV: begin
            w.div_step = 1'b1;
            w.cond     = COND_DIV_BUSY;
            w.target   = STEP_DIV;
         end
         STEP_EMIT: begin
            w.emit   = 1'b1;
            w.cond   = COND_OUT_BUSY;
            w.target = STEP_EMIT;
         end
         STEP_ZERO: begin
            w.emit_zero = 1'b1;
            w.cond      = COND_OUT_BUSY;
            w.target    = STEP_ZERO;
         end
         default: begin
            w.cond   = COND_ALWAYS;
            w.target = STEP_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

// File: hw/rtl/rar_if.sv
// request and response channel interfaces of the fraction adder
// no dependencies
interface rar_req_if #(
   parameter int W = 16
);
   logic                valid;
   logic                ready;
   logic signed [W-1:0] a_num;
   logic        [W-2:0] a_den;
   logic signed [W-1:0] b_num;
   logic        [W-2:0] b_den;

   modport source (output valid, a_num, a_den, b_num, b_den, input ready);
   modport sink   (input valid, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rar_rsp_if #(
   parameter int W = 16
);
   logic                  valid;
   logic                  ready;
   logic signed [2*W-1:0] sum_num;
   logic        [2*W-3:0] sum_den;

   modport source (output valid, sum_num, sum_den, input ready);
   modport sink   (input valid, sum_num, sum_den, output ready);
endinterface

// File: hw/rtl/rar_seq.sv
// microcode sequencer: step counter, rom lookup and conditional jumps
// depends on rar_pkg
module rar_seq (
   input  logic                clock,
   input  logic                reset,
   input  rar_pkg::status_type status,
   output rar_pkg::ctrl_type   ctrl
);

   rar_pkg::step_type step_ff;
   rar_pkg::step_type step_in;
   logic              jump;

   assign ctrl = rar_pkg::ucode_rom(step_ff);

   always_comb begin
      case (ctrl.cond)
         rar_pkg::COND_NONE:     jump = 1'b0;
         rar_pkg::COND_ALWAYS:   jump = 1'b1;
         rar_pkg::COND_NO_REQ:   jump = ~status.req_valid;
         rar_pkg::COND_ACC_ZERO: jump = status.flags.acc_zero;
         rar_pkg::COND_GCD_BUSY: jump = status.flags.gcd_busy;
         rar_pkg::COND_DIV_BUSY: jump = status.flags.div_busy;
         rar_pkg::COND_OUT_BUSY: jump = ~status.out_free;
         default:                jump = 1'b0;
      endcase
      step_in = jump ? ctrl.target : rar_pkg::step_type'(step_ff + 1'b1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= rar_pkg::STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

// File: hw/rtl/rar_dp.sv
// datapath: shared multiplier, accumulator, binary gcd and twin bit-serial divider
// depends on rar_pkg
module rar_dp #(
   parameter int W = 16
) (
   input  logic                  clock,
   input  rar_pkg::ctrl_type     ctrl,
   input  logic                  req_valid,
   input  logic                  out_free,
   input  logic signed [W-1:0]   a_num,
   input  logic        [W-2:0]   a_den,
   input  logic signed [W-1:0]   b_num,
   input  logic        [W-2:0]   b_den,
   output rar_pkg::dp_flags_type flags,
   output logic signed [2*W-1:0] sum_num,
   output logic        [2*W-3:0] sum_den
);

   localparam int DW = 2 * W;
   localparam int CW = $clog2(DW);
   localparam logic [CW-1:0] DIV_LAST = CW'(DW - 1);

   logic signed [W-1:0]  an_ff, bn_ff;
   logic        [W-2:0]  ad_ff, bd_ff;
   logic signed [W-1:0]  m_a, m_b;
   logic signed [DW-1:0] prod_ff, prod_in;
   logic signed [DW-1:0] acc_ff, acc_in;
   logic        [DW-1:0] mag;
   logic        [DW-1:0] x_ff, x_in, y_ff, y_in;
   logic        [DW-1:0] qn_ff, qn_in, qd_ff, qd_in;
   logic        [DW-1:0] rn_ff, rn_in, rd_ff, rd_in;
   logic        [DW:0]   rn_sh, rd_sh, x_ext;
   logic        [CW-1:0] cnt_ff, cnt_in;
   logic                 neg_ff, neg_in;
   logic signed [DW-1:0] out_num_ff, out_num_in;
   logic        [DW-3:0] out_den_ff, out_den_in;
   logic                 load_req;

   assign load_req = ctrl.take & req_valid;

   always_comb begin
      case (ctrl.mul_sel)
         rar_pkg::MUL_AN_BD: begin
            m_a = an_ff;
            m_b = signed'({1'b0, bd_ff});
         end
         rar_pkg::MUL_AD_BN: begin
            m_a = signed'({1'b0, ad_ff});
            m_b = bn_ff;
         end
         rar_pkg::MUL_AD_BD: begin
            m_a = signed'({1'b0, ad_ff});
            m_b = signed'({1'b0, bd_ff});
         end
         default: begin
            m_a = '0;
            m_b = '0;
         end
      endcase
      prod_in = DW'(m_a) * DW'(m_b);
   end

   always_comb begin
      case (ctrl.acc_op)
         rar_pkg::ACC_LOAD: acc_in = prod_ff;
         rar_pkg::ACC_ADD:  acc_in = acc_ff + prod_ff;
         default:           acc_in = acc_ff;
      endcase
   end

   assign mag = acc_ff[DW-1] ? unsigned'(-acc_ff) : unsigned'(acc_ff);

   assign x_ext = {1'b0, x_ff};
   assign rn_sh = {rn_ff, qn_ff[DW-1]};
   assign rd_sh = {rd_ff, qd_ff[DW-1]};

   always_comb begin
      x_in   = x_ff;
      y_in   = y_ff;
      qn_in  = qn_ff;
      qd_in  = qd_ff;
      rn_in  = rn_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      neg_in = neg_ff;
      if (ctrl.load_gcd) begin
         x_in   = mag;
         y_in   = unsigned'(prod_ff);
         qn_in  = mag;
         qd_in  = unsigned'(prod_ff);
         neg_in = acc_ff[DW-1];
      end
      if (ctrl.gcd_step && (x_ff != y_ff)) begin
         if (!x_ff[0] && !y_ff[0]) begin
            x_in  = x_ff >> 1;
            y_in  = y_ff >> 1;
            qn_in = qn_ff >> 1;
            qd_in = qd_ff >> 1;
         end else if (!x_ff[0]) begin
            x_in = x_ff >> 1;
         end else if (!y_ff[0]) begin
            y_in = y_ff >> 1;
         end else if (x_ff > y_ff) begin
            x_in = (x_ff - y_ff) >> 1;
         end else begin
            y_in = (y_ff - x_ff) >> 1;
         end
      end
      if (ctrl.div_init) begin
         rn_in  = '0;
         rd_in  = '0;
         cnt_in = '0;
      end
      if (ctrl.div_step) begin
         cnt_in = cnt_ff + 1'b1;
         if (rn_sh >= x_ext) begin
            rn_in = DW'(rn_sh - x_ext);
            qn_in = {qn_ff[DW-2:0], 1'b1};
         end else begin
            rn_in = rn_sh[DW-1:0];
            qn_in = {qn_ff[DW-2:0], 1'b0};
         end
         if (rd_sh >= x_ext) begin
            rd_in = DW'(rd_sh - x_ext);
            qd_in = {qd_ff[DW-2:0], 1'b1};
         end else begin
            rd_in = rd_sh[DW-1:0];
            qd_in = {qd_ff[DW-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      out_num_in = out_num_ff;
      out_den_in = out_den_ff;
      if (out_free && ctrl.emit) begin
         out_num_in = neg_ff ? -signed'(qn_ff) : signed'(qn_ff);
         out_den_in = qd_ff[DW-3:0];
      end else if (out_free && ctrl.emit_zero) begin
         out_num_in = '0;
         out_den_in = (DW-2)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (load_req) begin
         an_ff <= a_num;
         bn_ff <= b_num;
         ad_ff <= (a_den == '0) ? (W-1)'(1) : a_den;
         bd_ff <= (b_den == '0) ? (W-1)'(1) : b_den;
      end
      prod_ff    <= prod_in;
      acc_ff     <= acc_in;
      x_ff       <= x_in;
      y_ff       <= y_in;
      qn_ff      <= qn_in;
      qd_ff      <= qd_in;
      rn_ff      <= rn_in;
      rd_ff      <= rd_in;
      cnt_ff     <= cnt_in;
      neg_ff     <= neg_in;
      out_num_ff <= out_num_in;
      out_den_ff <= out_den_in;
   end

   assign flags.acc_zero = (acc_ff == '0);
   assign flags.gcd_busy = (x_ff != y_ff);
   assign flags.div_busy = (cnt_ff != DIV_LAST);

   assign sum_num = out_num_ff;
   assign sum_den = out_den_ff;

endmodule

// File: hw/rtl/rational_add_reduce.sv
// top level of the fraction adder with gcd reduction
// depends on rar_pkg, rar_if, rar_seq, rar_dp and assert_macros.svh
//
// Adds a_num/a_den and b_num/b_den and returns the sum in lowest terms with a
// positive denominator; a zero sum comes back as 0/1 and a zero denominator is
// read as 1. One request is worked at a time by a small microcoded sequencer:
// three multiply steps on one shared multiplier, a binary gcd loop that takes
// one iteration per cycle, then both divisions by what is left of the gcd run
// side by side in a bit-serial divider. A zero sum skips the gcd loop and the
// divider, and either path waits for the output register to free up.
// The result sits in an output register, so the next request can be started
// while the previous result waits to be taken. Both channel interfaces must
// be built with W equal to OPERAND_WIDTH.
`include "assert_macros.svh"

module rational_add_reduce #(
   parameter int OPERAND_WIDTH = 16
) (
   input logic      clock,
   input logic      reset,
   rar_req_if.sink  req_chan,
   rar_rsp_if.source rsp_chan
);

   rar_pkg::ctrl_type     ctrl;
   rar_pkg::status_type   status;
   rar_pkg::dp_flags_type flags;
   logic                  out_valid_ff, out_valid_in;
   logic                  out_free;

   assign out_free = ~out_valid_ff | rsp_chan.ready;

   assign status.req_valid = req_chan.valid;
   assign status.out_free  = out_free;
   assign status.flags     = flags;

   rar_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   rar_dp #(
      .W (OPERAND_WIDTH)
   ) u_dp (
      .clock     (clock),
      .ctrl      (ctrl),
      .req_valid (req_chan.valid),
      .out_free  (out_free),
      .a_num     (req_chan.a_num),
      .a_den     (req_chan.a_den),
      .b_num     (req_chan.b_num),
      .b_den     (req_chan.b_den),
      .flags     (flags),
      .sum_num   (rsp_chan.sum_num),
      .sum_den   (rsp_chan.sum_den)
   );

   always_comb begin
      out_valid_in = out_valid_ff & ~rsp_chan.ready;
      if (out_free && (ctrl.emit || ctrl.emit_zero)) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   assign req_chan.ready = ctrl.take;
   assign rsp_chan.valid = out_valid_ff;

   `RAR_ASSERT_NEXT(a_busy_after_req, clock, reset, req_chan.valid && req_chan.ready, !req_chan.ready)
   `RAR_ASSERT_IMPLY(a_den_nonzero, clock, reset, rsp_chan.valid, rsp_chan.sum_den != '0)
   `RAR_ASSERT_IMPLY(a_zero_is_unit_den, clock, reset, rsp_chan.valid && (rsp_chan.sum_num == '0), rsp_chan.sum_den == 1)

endmodule

// File: bench/rational_sum_checker.sv
// checker for the fraction adder: predicts the reduced sum of every accepted request
// and compares it with each accepted response, counting failures
// depends on nothing but its ports
`timescale 1ns / 1ps

module rational_sum_checker #(
   parameter int OPERAND_WIDTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic signed [OPERAND_WIDTH-1:0]   req_a_num,
   input  logic        [OPERAND_WIDTH-2:0]   req_a_den,
   input  logic signed [OPERAND_WIDTH-1:0]   req_b_num,
   input  logic        [OPERAND_WIDTH-2:0]   req_b_den,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic signed [2*OPERAND_WIDTH-1:0] rsp_sum_num,
   input  logic        [2*OPERAND_WIDTH-3:0] rsp_sum_den,
   output int                                fail_count,
   output int                                open_count
);

   typedef struct packed {
      logic signed [2*OPERAND_WIDTH-1:0] sum_num;
      logic        [2*OPERAND_WIDTH-3:0] sum_den;
   } reduced_sum_type;

   reduced_sum_type expected_sums[$];

   function automatic reduced_sum_type reduce_sum(
      input logic signed [OPERAND_WIDTH-1:0] an,
      input logic        [OPERAND_WIDTH-2:0] ad,
      input logic signed [OPERAND_WIDTH-1:0] bn,
      input logic        [OPERAND_WIDTH-2:0] bd
   );
      longint          ad_v;
      longint          bd_v;
      longint          num;
      longint unsigned mag;
      longint unsigned den;
      longint unsigned x;
      longint unsigned y;
      longint unsigned t;
      bit              neg;
      reduced_sum_type r;
      // a zero denominator reads as one
      ad_v = (ad == '0) ? 64'sd1 : longint'({1'b0, ad});
      bd_v = (bd == '0) ? 64'sd1 : longint'({1'b0, bd});
      num  = longint'(an) * bd_v + ad_v * longint'(bn);
      den  = longint'(ad_v * bd_v);
      neg  = num < 0;
      mag  = neg ? longint'(-num) : longint'(num);
      x = mag;
      y = den;
      while (y != 0) begin
         t = x % y;
         x = y;
         y = t;
      end
      if (x == 0)
         x = 1;
      mag = mag / x;
      den = den / x;
      if (mag == 0)
         den = 1;
      r.sum_num = (2*OPERAND_WIDTH)'(neg ? -mag : mag);
      r.sum_den = (2*OPERAND_WIDTH-2)'(den);
      return r;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      open_count = 0;
   end

   always @(posedge clock) begin : watch
      reduced_sum_type want;
      if (!reset) begin
         if (req_valid && req_ready)
            expected_sums.push_back(reduce_sum(req_a_num, req_a_den, req_b_num, req_b_den));
         if (rsp_valid && rsp_ready) begin
            if (expected_sums.size() == 0) begin
               report_mismatch("response with no request waiting", longint'(rsp_sum_num),
                               64'sd0);
            end else begin
               want = expected_sums.pop_front();
               if (rsp_sum_num !== want.sum_num)
                  report_mismatch("sum_num", longint'(rsp_sum_num), longint'(want.sum_num));
               if (rsp_sum_den !== want.sum_den)
                  report_mismatch("sum_den", longint'(rsp_sum_den), longint'(want.sum_den));
            end
         end
         open_count <= expected_sums.size();
      end
   end

endmodule

// File: bench/rational_add_reduce_test.sv
// top of the fraction adder bench: clock, reset, request and response traffic
// depends on rar_if, rational_add_reduce and rational_sum_checker
`timescale 1ns / 1ps

module rational_add_reduce_test;

   localparam int W           = 16;
   localparam int HOLD_CYCLES = 800;

   logic clock = 1'b0;
   logic reset;
   int   fail_count;
   int   open_count;
   int   req_idle_pct;
   int   rsp_stall_pct;
   bit   hold_request;

   rar_req_if #(.W(W)) req_chan ();
   rar_rsp_if #(.W(W)) rsp_chan ();

   rational_add_reduce #(.OPERAND_WIDTH(W)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   rational_sum_checker #(.OPERAND_WIDTH(W)) sum_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_ready   (req_chan.ready),
      .req_a_num   (req_chan.a_num),
      .req_a_den   (req_chan.a_den),
      .req_b_num   (req_chan.b_num),
      .req_b_den   (req_chan.b_den),
      .rsp_valid   (rsp_chan.valid),
      .rsp_ready   (rsp_chan.ready),
      .rsp_sum_num (rsp_chan.sum_num),
      .rsp_sum_den (rsp_chan.sum_den),
      .fail_count  (fail_count),
      .open_count  (open_count)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      #10_000_000;
      $display("== FAIL ==");
      $finish;
   end

   // response side, with the long hold-off counted here
   initial begin : receiver
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            for (int i = 0; i < HOLD_CYCLES; i++) begin
               rsp_chan.ready <= 1'b0;
               @(posedge clock);
            end
         end
         rsp_chan.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   task automatic send_request(input int an, input int ad, input int bn, input int bd);
      while ($urandom_range(99) < req_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.a_num <= W'(an);
      req_chan.a_den <= (W-1)'(ad);
      req_chan.b_num <= W'(bn);
      req_chan.b_den <= (W-1)'(bd);
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
   endtask

   task automatic send_random_request();
      int kind;
      int f;
      int an;
      int ad;
      int bn;
      int bd;
      kind = $urandom_range(99);
      if (kind < 35) begin
         an = $urandom;
         ad = $urandom;
         bn = $urandom;
         bd = $urandom;
      end else if (kind < 65) begin
         an = int'($urandom_range(200)) - 100;
         ad = $urandom_range(40);
         bn = int'($urandom_range(200)) - 100;
         bd = $urandom_range(40);
      end else if (kind < 80) begin
         // sums that cancel to zero
         an = ($urandom_range(1)) ? int'($urandom_range(200)) - 100 : int'($urandom);
         ad = $urandom;
         bn = -an;
         bd = ad;
      end else begin
         // shared factors so the reduction has work to do
         f  = $urandom_range(1, 180);
         an = (int'($urandom_range(340)) - 170) * f;
         ad = $urandom_range(1, 180) * f;
         bn = (int'($urandom_range(340)) - 170) * f;
         bd = $urandom_range(1, 180) * f;
      end
      send_request(an, ad, bn, bd);
   endtask

   task automatic wait_for_results();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      wait (open_count == 0);
      @(posedge clock);
   endtask

   initial begin : stimulus
      reset          = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.a_num = '0;
      req_chan.a_den = '0;
      req_chan.b_num = '0;
      req_chan.b_den = '0;
      req_idle_pct   = 0;
      rsp_stall_pct  = 0;
      hold_request   = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_request(-32768, 32767, -32768, 32767);
      send_request(32767, 1, 32767, 1);
      send_request(-32768, 1, -32768, 1);
      send_request(32767, 32767, 32767, 32767);
      send_request(1, 32767, 1, 32766);
      send_request(-1, 32767, -1, 32766);
      send_request(-32768, 32767, 32767, 32766);
      send_request(7, 0, 5, 0);
      send_request(-3, 0, 1, 4);
      send_request(5, 3, -5, 3);
      send_request(0, 7, 0, 9);
      send_request(1, 2, 1, 2);
      send_request(1, 6, 1, 3);
      send_request(-1, 6, 1, 3);
      send_request(0, 0, 0, 0);
      send_request(32767, 16384, -32768, 21845);
      send_request(12, 18, -30, 45);
      send_request(-32768, 2, 32767, 1);
      wait_for_results();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               req_idle_pct  = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               req_idle_pct  = 47;
               rsp_stall_pct = 0;
            end
            2: begin
               req_idle_pct  = 0;
               rsp_stall_pct = 47;
            end
            default: begin
               req_idle_pct  = 37;
               rsp_stall_pct = 37;
            end
         endcase
         if (phase == 0) begin
            // fill the block while responses are held off
            hold_request = 1'b1;
            repeat (40) send_random_request();
         end
         repeat (250) send_random_request();
         wait_for_results();
      end

      repeat (150) @(posedge clock);
      if (fail_count == 0 && open_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/rar_pkg.sv
hw/rtl/rar_if.sv
hw/rtl/rar_seq.sv
hw/rtl/rar_dp.sv
hw/rtl/rational_add_reduce.sv
bench/rational_sum_checker.sv
bench/rational_add_reduce_test.sv
